[rtl/cpu_frequency_governor_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the CPU frequency governor
// Concurrent assertion helpers shared by the RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef CPU_FREQUENCY_GOVERNOR_TOP_MACROS_SVH
`define CPU_FREQUENCY_GOVERNOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising edge outside reset.
`define CFGOV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cfgov assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define CFGOV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cfgov assertion failed");
`else
`define CFGOV_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CFGOV_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/cfgov_pkg.sv]
// ----------------------------------------------------------------------------
// cfgov_pkg
// Types and constants of the CPU frequency governor.
// ----------------------------------------------------------------------------
`default_nettype none

package cfgov_pkg;

	localparam int LOAD_W = 7;
	localparam int FREQ_W = 8;
	localparam int MODE_W = 3;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int PROD_W = FREQ_W + LOAD_W;

	typedef logic [LOAD_W-1:0] load_t;
	typedef logic [FREQ_W-1:0] freq_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [1:0]        reg_idx_t;

	// Policy codes held in the mode register.
	localparam mode_t MODE_USER         = 3'd0;
	localparam mode_t MODE_ONDEMAND     = 3'd1;
	localparam mode_t MODE_PERFORMANCE  = 3'd2;
	localparam mode_t MODE_POWERSAVE    = 3'd3;
	localparam mode_t MODE_CONSERVATIVE = 3'd4;
	localparam mode_t MODE_LOAD_PROP    = 3'd5;

	// Register indexes (byte address / 4).
	localparam reg_idx_t REG_MODE      = 2'd0;
	localparam reg_idx_t REG_USER_FREQ = 2'd1;
	localparam reg_idx_t REG_MIN_FREQ  = 2'd2;
	localparam reg_idx_t REG_MAX_FREQ  = 2'd3;

	// Register reset values.
	localparam mode_t RST_MODE      = MODE_USER;
	localparam freq_t RST_USER_FREQ = 8'd255;
	localparam freq_t RST_MIN_FREQ  = 8'd100;
	localparam freq_t RST_MAX_FREQ  = 8'd255;

	localparam load_t FULL_LOAD = 7'd100;

	// Reciprocal constants: floor(n/d) = (n * RECIP) >> SHIFT, exact over the
	// value range that reaches each divider.
	localparam int RECIP_100 = 5243;
	localparam int SHIFT_100 = 19;
	localparam int RECIP_10  = 205;
	localparam int SHIFT_10  = 11;
	localparam int RECIP_5   = 205;
	localparam int SHIFT_5   = 10;

endpackage

`default_nettype wire

[rtl/cfgov_in_if.sv]
// ----------------------------------------------------------------------------
// cfgov_in_if
// Load sample channel: one core load per item, the tick's last core marked.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfgov_in_if;
	logic                          valid;
	logic                          ready;
	logic [cfgov_pkg::LOAD_W-1:0]  core_load;
	logic [cfgov_pkg::FREQ_W-1:0]  current_freq;
	logic                          last_core;

	modport source (output valid, output core_load, output current_freq,
		output last_core, input ready);
	modport sink (input valid, input core_load, input current_freq,
		input last_core, output ready);
endinterface

`default_nettype wire

[rtl/cfgov_out_if.sv]
// ----------------------------------------------------------------------------
// cfgov_out_if
// Decision channel: one item per tick with the frequency to program.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfgov_out_if;
	logic                          valid;
	logic                          ready;
	logic                          change_needed;
	logic [cfgov_pkg::FREQ_W-1:0]  new_freq;

	modport source (output valid, output change_needed, output new_freq,
		input ready);
	modport sink (input valid, input change_needed, input new_freq,
		output ready);
endinterface

`default_nettype wire

[rtl/cpu_frequency_governor_top.sv]
// ----------------------------------------------------------------------------
// cpu_frequency_governor_top
// Per-tick DVFS governor: tracks peak core load and picks the next frequency.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake        Payload
// in_ch     in   valid / ready    core_load, current_freq, last_core
// out_ch    out  valid / ready    change_needed, new_freq
// APB       in   psel / penable   paddr, pwdata (write), prdata (read)
//
// The block takes one load item per cycle while in_ch.ready is high. A tick's
// decision reaches out_ch after its last item is accepted. The acceptance edge
// loads the input register, and the item then passes the load-times-gap
// product stage, the divide-by-100 stage and the result register.
// Items that are not last leave no result. Each stage holds its item while
// the stage after it is full and stalled, so a waiting result blocks input
// only once every stage in front of it is occupied.
// Reset clears the pipeline, the per-tick peak and full-core flag, and loads
// the register reset values; no clearing pass is needed.
//
`default_nettype none

`include "cpu_frequency_governor_top_macros.svh"

module cpu_frequency_governor_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cfgov_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [cfgov_pkg::DATA_W-1:0]  pwdata,
	output      logic [cfgov_pkg::DATA_W-1:0]  prdata,
	output      logic                          pready,
	cfgov_in_if.sink                           in_ch,
	cfgov_out_if.source                        out_ch
);

	// ------------------------------------------------------------------
	// Configuration registers. The register index is the word address.
	// ------------------------------------------------------------------
	cfgov_pkg::mode_t    mode_q;
	cfgov_pkg::freq_t    user_freq_q;
	cfgov_pkg::freq_t    min_freq_q;
	cfgov_pkg::freq_t    max_freq_q;
	cfgov_pkg::reg_idx_t reg_idx;
	logic                cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= cfgov_pkg::RST_MODE;
			user_freq_q <= cfgov_pkg::RST_USER_FREQ;
			min_freq_q  <= cfgov_pkg::RST_MIN_FREQ;
			max_freq_q  <= cfgov_pkg::RST_MAX_FREQ;
		end else if (cfg_wr) begin
			case (reg_idx)
				cfgov_pkg::REG_MODE:      mode_q      <= pwdata[cfgov_pkg::MODE_W-1:0];
				cfgov_pkg::REG_USER_FREQ: user_freq_q <= pwdata[cfgov_pkg::FREQ_W-1:0];
				cfgov_pkg::REG_MIN_FREQ:  min_freq_q  <= pwdata[cfgov_pkg::FREQ_W-1:0];
				cfgov_pkg::REG_MAX_FREQ:  max_freq_q  <= pwdata[cfgov_pkg::FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			cfgov_pkg::REG_MODE:      prdata = 32'(mode_q);
			cfgov_pkg::REG_USER_FREQ: prdata = 32'(user_freq_q);
			cfgov_pkg::REG_MIN_FREQ:  prdata = 32'(min_freq_q);
			cfgov_pkg::REG_MAX_FREQ:  prdata = 32'(max_freq_q);
			default:                  prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. Each stage moves on when the next one is
	// empty or moving itself.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, out_valid_q;
	logic adv_out, adv_s3, adv_s2, adv_s1;

	assign adv_out     = !out_valid_q || out_ch.ready;
	assign adv_s3      = !v_s3 || adv_out;
	assign adv_s2      = !v_s2 || adv_s3;
	assign adv_s1      = !v_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	// ------------------------------------------------------------------
	// Stage 1: input register.
	// ------------------------------------------------------------------
	cfgov_pkg::load_t load_s1;
	cfgov_pkg::freq_t freq_s1;
	logic             last_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			load_s1 <= in_ch.core_load;
			freq_s1 <= in_ch.current_freq;
			last_s1 <= in_ch.last_core;
		end
	end

	// ------------------------------------------------------------------
	// Per-tick accumulation. The item in stage 1 is folded into the peak
	// and the full-core flag; the last item of a tick uses the folded
	// values and then clears them for the next tick.
	// ------------------------------------------------------------------
	cfgov_pkg::load_t peak_q;
	logic             full_q;
	cfgov_pkg::load_t load_sat;
	cfgov_pkg::load_t peak_eff;
	logic             full_eff;
	logic             take_s1;

	assign take_s1  = v_s1 && adv_s2;
	assign load_sat = (load_s1 > cfgov_pkg::FULL_LOAD) ? cfgov_pkg::FULL_LOAD : load_s1;
	assign peak_eff = (load_sat > peak_q) ? load_sat : peak_q;
	assign full_eff = full_q || (load_sat == cfgov_pkg::FULL_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			full_q <= 1'b0;
		end else if (take_s1) begin
			if (last_s1) begin
				peak_q <= '0;
				full_q <= 1'b0;
			end else begin
				peak_q <= peak_eff;
				full_q <= full_eff;
			end
		end
	end

	// Operands for stage 2: the load-proportional product and the gap that
	// conservative mode would close.
	cfgov_pkg::freq_t               gap;
	logic [cfgov_pkg::PROD_W-1:0]   prod;
	logic                           move;
	cfgov_pkg::freq_t               diff;

	always_comb begin
		gap  = (max_freq_q > min_freq_q) ? (max_freq_q - min_freq_q) : '0;
		prod = (cfgov_pkg::PROD_W)'(gap) * (cfgov_pkg::PROD_W)'(peak_eff);
		if (full_eff) begin
			move = freq_s1 < max_freq_q;
			diff = max_freq_q - freq_s1;
		end else begin
			move = freq_s1 > min_freq_q;
			diff = freq_s1 - min_freq_q;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: only last items travel on from here.
	// ------------------------------------------------------------------
	logic [cfgov_pkg::PROD_W-1:0] prod_s2;
	cfgov_pkg::freq_t             freq_s2;
	cfgov_pkg::freq_t             diff_s2;
	logic                         full_s2;
	logic                         move_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			prod_s2 <= prod;
			freq_s2 <= freq_s1;
			diff_s2 <= diff;
			full_s2 <= full_eff;
			move_s2 <= move;
		end
	end

	// Divide the product by 100 and the gap by 10, both by reciprocal.
	localparam int QW100 = cfgov_pkg::PROD_W + 13;
	localparam int QW10  = cfgov_pkg::FREQ_W + 8;

	logic [QW100-1:0]           quo100_full;
	cfgov_pkg::freq_t           quo100;
	logic [cfgov_pkg::FREQ_W:0] lp_sum;
	logic [QW10-1:0]            quo10_full;
	logic [4:0]                 quo10;
	logic [6:0]                 step;
	cfgov_pkg::freq_t           cons_freq;

	always_comb begin
		quo100_full = QW100'(prod_s2) * QW100'(cfgov_pkg::RECIP_100);
		quo100      = quo100_full[cfgov_pkg::SHIFT_100 +: cfgov_pkg::FREQ_W];
		lp_sum      = (cfgov_pkg::FREQ_W+1)'(min_freq_q) + (cfgov_pkg::FREQ_W+1)'(quo100);
		quo10_full  = QW10'(diff_s2) * QW10'(cfgov_pkg::RECIP_10);
		quo10       = quo10_full[cfgov_pkg::SHIFT_10 +: 5];
		step        = 7'(quo10) * 7'd5;
		if (!move_s2) begin
			cons_freq = freq_s2;
		end else if (full_s2) begin
			cons_freq = freq_s2 + 8'(step);
		end else begin
			cons_freq = freq_s2 - 8'(step);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3.
	// ------------------------------------------------------------------
	cfgov_pkg::freq_t lp_s3;
	cfgov_pkg::freq_t cons_s3;
	cfgov_pkg::freq_t freq_s3;
	logic             full_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			lp_s3   <= lp_sum[cfgov_pkg::FREQ_W-1:0];
			cons_s3 <= cons_freq;
			freq_s3 <= freq_s2;
			full_s3 <= full_s2;
		end
	end

	// Round the load-proportional value down to a multiple of 5, then pick
	// the policy's target.
	localparam int QW5 = cfgov_pkg::FREQ_W + 10;

	logic [QW5-1:0]   quo5_full;
	logic [5:0]       quo5;
	logic [8:0]       lp_round;
	cfgov_pkg::freq_t target;

	always_comb begin
		quo5_full = QW5'(lp_s3) * QW5'(cfgov_pkg::RECIP_5);
		quo5      = quo5_full[cfgov_pkg::SHIFT_5 +: 6];
		lp_round  = 9'(quo5) * 9'd5;
		case (mode_q)
			cfgov_pkg::MODE_ONDEMAND:     target = full_s3 ? max_freq_q : min_freq_q;
			cfgov_pkg::MODE_PERFORMANCE:  target = max_freq_q;
			cfgov_pkg::MODE_POWERSAVE:    target = min_freq_q;
			cfgov_pkg::MODE_CONSERVATIVE: target = cons_s3;
			cfgov_pkg::MODE_LOAD_PROP:    target = lp_round[cfgov_pkg::FREQ_W-1:0];
			default:                      target = user_freq_q;
		endcase
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	logic             change_q;
	cfgov_pkg::freq_t new_freq_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			change_q   <= target != freq_s3;
			new_freq_q <= target;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_ch.valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1 && last_s1;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.change_needed = change_q;
	assign out_ch.new_freq      = new_freq_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// The running peak never exceeds a full load.
	`CFGOV_ASSERT_IMP(a_peak_range, clk, arst_n, 1'b1, peak_q <= cfgov_pkg::FULL_LOAD)
	// A full core implies the peak already reached a full load.
	`CFGOV_ASSERT_IMP(a_full_peak, clk, arst_n, full_q, peak_q == cfgov_pkg::FULL_LOAD)
	// The end of a tick leaves clean state for the next tick.
	`CFGOV_ASSERT_NXT(a_tick_clear, clk, arst_n, take_s1 && last_s1, peak_q == '0 && !full_q)
	// A stalled result keeps the stage in front of it from moving.
	`CFGOV_ASSERT_IMP(a_stall_hold, clk, arst_n, out_valid_q && !out_ch.ready && v_s3, !adv_s3)

endmodule

`default_nettype wire
